// ===== rtl/core/m3i_pkg.sv =====
// Package for the 3x3 fixed-point matrix inverse: word and stage widths,
// payload types and register codes. No dependencies.
package m3i_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int N_ELEM  = 9;
  localparam int PROD_W  = 2 * WORD_BITS;
  localparam int ADJ_W   = 2 * WORD_BITS + 1;
  localparam int MAG_W   = 2 * WORD_BITS;
  localparam int NUM_W   = MAG_W + 2 * FRAC_BITS;
  localparam int DET_W   = 3 * WORD_BITS + 3;
  localparam int DMAG_W  = DET_W - 1;
  localparam int CMP_W   = (NUM_W > DMAG_W + WORD_BITS + 1) ? NUM_W : DMAG_W + WORD_BITS + 1;
  localparam int Q_W     = WORD_BITS + 2;

  localparam int FRONT_ST = 6;
  localparam int LANE_ST  = WORD_BITS + 3;
  localparam int PIPE_ST  = FRONT_ST + LANE_ST;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [0:0] REG_TRANSPOSE = 1'b0;

  typedef logic signed [WORD_BITS-1:0] elem_t;
  typedef logic [NUM_W-1:0]            num_t;
  typedef logic [DMAG_W-1:0]           dmag_t;
  typedef logic [Q_W-1:0]              quot_t;
  typedef logic [CMP_W-1:0]            cmp_t;

  typedef struct packed {
    dmag_t dmag;
    logic  singular;
  } det_info_t;

  typedef struct packed {
    quot_t q;
    logic  big;
    logic  neg;
  } lane_res_t;

  typedef struct packed {
    logic [N_ELEM-1:0][WORD_BITS-1:0] m;
    logic                             singular;
    logic                             overflowed;
  } out_item_t;

endpackage

// ===== rtl/core/m3i_in_if.sv =====
// Input channel of the matrix inverse: valid, ready and nine elements.
// Depends on m3i_pkg.
interface m3i_in_if;
  logic valid;
  logic ready;
  m3i_pkg::elem_t in_r0c0;
  m3i_pkg::elem_t in_r0c1;
  m3i_pkg::elem_t in_r0c2;
  m3i_pkg::elem_t in_r1c0;
  m3i_pkg::elem_t in_r1c1;
  m3i_pkg::elem_t in_r1c2;
  m3i_pkg::elem_t in_r2c0;
  m3i_pkg::elem_t in_r2c1;
  m3i_pkg::elem_t in_r2c2;

  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

// ===== rtl/core/m3i_out_if.sv =====
// Output channel of the matrix inverse: valid, ready, nine elements, flags.
// Depends on m3i_pkg.
interface m3i_out_if;
  logic valid;
  logic ready;
  m3i_pkg::elem_t out_r0c0;
  m3i_pkg::elem_t out_r0c1;
  m3i_pkg::elem_t out_r0c2;
  m3i_pkg::elem_t out_r1c0;
  m3i_pkg::elem_t out_r1c1;
  m3i_pkg::elem_t out_r1c2;
  m3i_pkg::elem_t out_r2c0;
  m3i_pkg::elem_t out_r2c1;
  m3i_pkg::elem_t out_r2c2;
  logic singular;
  logic overflowed;

  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                  out_r2c0, out_r2c1, out_r2c2, singular, overflowed, input ready);
  modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                out_r2c0, out_r2c1, out_r2c2, singular, overflowed, output ready);
endinterface

// ===== rtl/core/matrix3_inverse.sv =====
// Top level of the 3x3 signed fixed-point matrix inverse.
// Depends on m3i_pkg, m3i_in_if, m3i_out_if, m3i_cfg, m3i_front, m3i_div_lane.
//
// Usage:
//   in_i carries one matrix per item, nine Q16.16 elements in row-major order.
//   out_o carries the inverse (or its transpose when transpose_out is set),
//   saturated, with a singular flag (all elements zero) and an overflow flag.
//   The APB port holds transpose_out at address 0; write it only while idle.
// Pipeline: six front stages (input register, products, cofactors,
//   determinant partial products, determinant sum, magnitudes), 35 divider
//   stages (range check, 33 quotient bits, rounding) and combinational
//   saturation feeding a two-entry output buffer.
// Throughput: one matrix per cycle unless held; nine parallel divider lanes.
// Stall: the whole pipeline advances while the output buffer holds at most
//   one item, so one finished item can wait while the next is accepted; with
//   two items waiting, in_i.ready drops and every stage holds.
// Reset: clears the pipeline valid bits, the output buffer and transpose_out.
module matrix3_inverse (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  m3i_in_if.sink                       in_i,
  m3i_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [m3i_pkg::ADDR_W-1:0]   paddr,
  input  logic [m3i_pkg::DATA_W-1:0]   pwdata,
  output logic [m3i_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int W  = m3i_pkg::WORD_BITS;
  localparam int NV = m3i_pkg::PIPE_ST;

  logic                          transpose;
  logic                          en;
  logic [NV-1:0]                 v_q;
  logic [1:0]                    cnt_q, cnt_d;
  logic                          push, pop;
  m3i_pkg::elem_t                elem [m3i_pkg::N_ELEM];
  m3i_pkg::num_t                 num  [m3i_pkg::N_ELEM];
  logic [m3i_pkg::N_ELEM-1:0]    neg;
  m3i_pkg::det_info_t            det;
  m3i_pkg::lane_res_t            res  [m3i_pkg::N_ELEM];
  logic [m3i_pkg::LANE_ST-1:0]   sing_q;
  logic [m3i_pkg::N_ELEM-1:0][W-1:0] val;
  logic [m3i_pkg::N_ELEM-1:0]    ovf;
  m3i_pkg::out_item_t            item;
  m3i_pkg::out_item_t            slot0_q, slot1_q;

  m3i_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .transpose_o (transpose)
  );

  assign en       = (cnt_q != 2'd2);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NV-2:0], in_i.valid};
    end
  end

  assign elem[0] = in_i.in_r0c0;
  assign elem[1] = in_i.in_r0c1;
  assign elem[2] = in_i.in_r0c2;
  assign elem[3] = in_i.in_r1c0;
  assign elem[4] = in_i.in_r1c1;
  assign elem[5] = in_i.in_r1c2;
  assign elem[6] = in_i.in_r2c0;
  assign elem[7] = in_i.in_r2c1;
  assign elem[8] = in_i.in_r2c2;

  m3i_front u_front (
    .clk_i  (clk_i),
    .en_i   ({m3i_pkg::FRONT_ST{en}}),
    .elem_i (elem),
    .num_o  (num),
    .neg_o  (neg),
    .det_o  (det)
  );

  for (genvar k = 0; k < m3i_pkg::N_ELEM; k++) begin : g_lane
    m3i_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   ({m3i_pkg::LANE_ST{en}}),
      .num_i  (num[k]),
      .neg_i  (neg[k]),
      .dmag_i (det.dmag),
      .res_o  (res[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= {sing_q[m3i_pkg::LANE_ST-2:0], det.singular};
    end
  end

  for (genvar k = 0; k < m3i_pkg::N_ELEM; k++) begin : g_sat
    m3i_pkg::quot_t lim;
    m3i_pkg::quot_t mag;
    logic [W-1:0]   mag_w;

    assign lim    = res[k].neg ? (m3i_pkg::quot_t'(1) << (W-1))
                               : (m3i_pkg::quot_t'(1) << (W-1)) - m3i_pkg::quot_t'(1);
    assign ovf[k] = res[k].big | (res[k].q > lim);
    assign mag    = ovf[k] ? lim : res[k].q;
    assign mag_w  = mag[W-1:0];
    assign val[k] = res[k].neg ? (~mag_w + 1'b1) : mag_w;
  end

  always_comb begin
    item.singular   = sing_q[m3i_pkg::LANE_ST-1];
    item.overflowed = ~item.singular & (|ovf);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (item.singular) begin
          item.m[r*3+c] = '0;
        end else if (transpose) begin
          item.m[r*3+c] = val[c*3+r];
        end else begin
          item.m[r*3+c] = val[r*3+c];
        end
      end
    end
  end

  assign push  = en & v_q[NV-1];
  assign pop   = out_o.valid & out_o.ready;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
      slot0_q <= item;
    end else if (pop && cnt_q == 2'd2) begin
      slot0_q <= slot1_q;
    end
    if (push && cnt_q == 2'd1 && !pop) begin
      slot1_q <= item;
    end
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.out_r0c0   = slot0_q.m[0];
  assign out_o.out_r0c1   = slot0_q.m[1];
  assign out_o.out_r0c2   = slot0_q.m[2];
  assign out_o.out_r1c0   = slot0_q.m[3];
  assign out_o.out_r1c1   = slot0_q.m[4];
  assign out_o.out_r1c2   = slot0_q.m[5];
  assign out_o.out_r2c0   = slot0_q.m[6];
  assign out_o.out_r2c1   = slot0_q.m[7];
  assign out_o.out_r2c2   = slot0_q.m[8];
  assign out_o.singular   = slot0_q.singular;
  assign out_o.overflowed = slot0_q.overflowed;

  a_singular_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.singular |-> !out_o.overflowed && out_o.out_r0c0 == '0 &&
      out_o.out_r1c1 == '0 && out_o.out_r2c2 == '0 && out_o.out_r0c2 == '0)
    else $error("singular item carries nonzero data");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[0])
    else $error("accepted item missing from first stage");

  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && cnt_q == 2'd2)
    else $error("input stalled without a full output buffer");

  a_no_overfill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push)
    else $error("push into full output buffer");

endmodule

// ===== rtl/core/m3i_cfg.sv =====
// APB-style register port of the matrix inverse holding transpose_out.
// Depends on m3i_pkg.
module m3i_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [m3i_pkg::ADDR_W-1:0]   paddr,
  input  logic [m3i_pkg::DATA_W-1:0]   pwdata,
  output logic [m3i_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic                         transpose_o
);

  logic       transpose_q;
  logic [0:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[m3i_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready & (reg_idx == m3i_pkg::REG_TRANSPOSE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_q <= 1'b0;
    end else if (wr_en) begin
      transpose_q <= pwdata[0];
    end
  end

  assign prdata = (reg_idx == m3i_pkg::REG_TRANSPOSE) ?
                  {{(m3i_pkg::DATA_W-1){1'b0}}, transpose_q} : '0;
  assign transpose_o = transpose_q;

endmodule

// ===== rtl/core/m3i_front.sv =====
// Front pipeline of the matrix inverse: products, adjugate cofactors,
// determinant, magnitudes and signs over six stages. Depends on m3i_pkg.
module m3i_front (
  input  logic                                clk_i,
  input  logic [m3i_pkg::FRONT_ST-1:0]        en_i,
  input  m3i_pkg::elem_t                      elem_i [m3i_pkg::N_ELEM],
  output m3i_pkg::num_t                       num_o  [m3i_pkg::N_ELEM],
  output logic [m3i_pkg::N_ELEM-1:0]          neg_o,
  output m3i_pkg::det_info_t                  det_o
);

  localparam int W = m3i_pkg::WORD_BITS;
  localparam int CfA [9] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int CfB [9] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int CfC [9] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int CfD [9] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  m3i_pkg::elem_t                      e_q    [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::PROD_W-1:0]   pa_q   [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::PROD_W-1:0]   pb_q   [m3i_pkg::N_ELEM];
  m3i_pkg::elem_t                      r0a_q  [3];
  m3i_pkg::elem_t                      r0b_q  [3];
  logic signed [m3i_pkg::ADJ_W-1:0]    adj2_q [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::ADJ_W-1:0]    adj3_q [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::ADJ_W-1:0]    adj4_q [m3i_pkg::N_ELEM];
  logic signed [2*W:0]                 lo_q   [3];
  logic signed [2*W:0]                 hi_q   [3];
  logic signed [m3i_pkg::DET_W-1:0]    det_q;
  logic signed [m3i_pkg::DET_W-1:0]    det_sum;
  logic signed [m3i_pkg::DET_W-1:0]    det_neg;
  m3i_pkg::num_t                       num_q  [m3i_pkg::N_ELEM];
  logic [m3i_pkg::N_ELEM-1:0]          neg_q;
  m3i_pkg::det_info_t                  det_info_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      e_q <= elem_i;
    end
  end

  for (genvar k = 0; k < m3i_pkg::N_ELEM; k++) begin : g_cof
    logic signed [m3i_pkg::ADJ_W-1:0] adj_neg;
    logic [m3i_pkg::MAG_W-1:0]        mag;

    always_ff @(posedge clk_i) begin
      if (en_i[1]) begin
        pa_q[k] <= e_q[CfA[k]] * e_q[CfB[k]];
        pb_q[k] <= e_q[CfC[k]] * e_q[CfD[k]];
      end
      if (en_i[2]) begin
        adj2_q[k] <= m3i_pkg::ADJ_W'(pa_q[k]) - m3i_pkg::ADJ_W'(pb_q[k]);
      end
      if (en_i[3]) begin
        adj3_q[k] <= adj2_q[k];
      end
      if (en_i[4]) begin
        adj4_q[k] <= adj3_q[k];
      end
    end

    assign adj_neg = -adj4_q[k];
    assign mag     = adj4_q[k][m3i_pkg::ADJ_W-1] ? adj_neg[m3i_pkg::MAG_W-1:0]
                                                 : adj4_q[k][m3i_pkg::MAG_W-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i[5]) begin
        num_q[k] <= {mag, {(2*m3i_pkg::FRAC_BITS){1'b0}}};
        neg_q[k] <= adj4_q[k][m3i_pkg::ADJ_W-1] ^ det_q[m3i_pkg::DET_W-1];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk_i) begin
      if (en_i[1]) begin
        r0a_q[j] <= e_q[j];
      end
      if (en_i[2]) begin
        r0b_q[j] <= r0a_q[j];
      end
      if (en_i[3]) begin
        lo_q[j] <= r0b_q[j] * $signed({1'b0, adj2_q[3*j][W-1:0]});
        hi_q[j] <= r0b_q[j] * $signed(adj2_q[3*j][m3i_pkg::ADJ_W-1:W]);
      end
    end
  end

  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + m3i_pkg::DET_W'($signed({hi_q[j], {W{1'b0}}}))
                        + m3i_pkg::DET_W'(lo_q[j]);
    end
  end

  assign det_neg = -det_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      det_q <= det_sum;
    end
    if (en_i[5]) begin
      det_info_q.dmag     <= det_q[m3i_pkg::DET_W-1] ? det_neg[m3i_pkg::DMAG_W-1:0]
                                                     : det_q[m3i_pkg::DMAG_W-1:0];
      det_info_q.singular <= (det_q == '0);
    end
  end

  assign num_o = num_q;
  assign neg_o = neg_q;
  assign det_o = det_info_q;

endmodule

// ===== rtl/core/m3i_div_lane.sv =====
// One divider lane: restoring division of a cofactor magnitude by the
// determinant magnitude, one quotient bit per stage, then rounding.
// Depends on m3i_pkg.
module m3i_div_lane (
  input  logic                          clk_i,
  input  logic [m3i_pkg::LANE_ST-1:0]   en_i,
  input  m3i_pkg::num_t                 num_i,
  input  logic                          neg_i,
  input  m3i_pkg::dmag_t                dmag_i,
  output m3i_pkg::lane_res_t            res_o
);

  localparam int LAST = m3i_pkg::LANE_ST - 1;

  m3i_pkg::cmp_t      rem_q [LAST];
  m3i_pkg::dmag_t     d_q   [LAST];
  m3i_pkg::quot_t     q_q   [LAST];
  logic               big_q [LAST];
  logic               neg_q [LAST];
  m3i_pkg::lane_res_t res_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= m3i_pkg::cmp_t'(num_i);
      d_q[0]   <= dmag_i;
      q_q[0]   <= '0;
      neg_q[0] <= neg_i;
      big_q[0] <= m3i_pkg::cmp_t'(num_i) >=
                  (m3i_pkg::cmp_t'(dmag_i) << (m3i_pkg::WORD_BITS + 1));
    end
  end

  for (genvar s = 1; s < LAST; s++) begin : g_step
    localparam int Bit = LAST - 1 - s;
    m3i_pkg::cmp_t sub;
    logic          take;

    assign sub  = m3i_pkg::cmp_t'(d_q[s-1]) << Bit;
    assign take = rem_q[s-1] >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= take ? rem_q[s-1] - sub : rem_q[s-1];
        d_q[s]   <= d_q[s-1];
        q_q[s]   <= q_q[s-1] | (m3i_pkg::quot_t'(take) << Bit);
        neg_q[s] <= neg_q[s-1];
        big_q[s] <= big_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LAST]) begin
      res_q.q   <= q_q[LAST-1] + m3i_pkg::quot_t'((rem_q[LAST-1] << 1) >=
                                                  m3i_pkg::cmp_t'(d_q[LAST-1]));
      res_q.big <= big_q[LAST-1];
      res_q.neg <= neg_q[LAST-1];
    end
  end

  assign res_o = res_q;

endmodule

// ===== test/matrix3_inverse_test.sv =====
// Testbench for matrix3_inverse: streams 3x3 Q16.16 matrices through the block
// and checks each inverse against an exact rational predictor, under idling and
// both transpose settings. Depends on m3i_pkg, m3i_in_if and m3i_out_if.
`timescale 1ns / 100ps

module matrix3_inverse_test;

  typedef logic [m3i_pkg::N_ELEM-1:0][m3i_pkg::WORD_BITS-1:0] matrix_t;
  typedef logic signed [127:0] wide_t;

  localparam int  CYCLE_LIMIT = 400000;
  localparam logic [m3i_pkg::ADDR_W-1:0] ADDR_TRANSPOSE =
    m3i_pkg::ADDR_W'(m3i_pkg::REG_TRANSPOSE) << 2;
  localparam int  SMALL_SPAN = 262144;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [m3i_pkg::ADDR_W-1:0] paddr;
  logic [m3i_pkg::DATA_W-1:0] pwdata, prdata;
  logic pready;

  m3i_in_if  in_ch();
  m3i_out_if out_ch();

  matrix3_inverse u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  matrix_t            pending_matrices[$];
  m3i_pkg::out_item_t expected_inverses[$];
  bit                 transpose_shadow;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  bit                 took_matrix;
  int                 fail_count;
  int                 cycle_count;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic m3i_pkg::out_item_t invert_matrix(matrix_t a, bit transpose);
    wide_t      e[9];
    wide_t      adj[9];
    wide_t      det, dmag, num, quot, rem;
    logic [m3i_pkg::WORD_BITS-1:0] res[9];
    m3i_pkg::out_item_t r;
    bit         neg;
    r = '0;
    for (int i = 0; i < 9; i++) e[i] = $signed(a[i]);
    adj[0] = e[4] * e[8] - e[7] * e[5];
    adj[1] = e[2] * e[7] - e[1] * e[8];
    adj[2] = e[1] * e[5] - e[2] * e[4];
    adj[3] = e[5] * e[6] - e[3] * e[8];
    adj[4] = e[0] * e[8] - e[2] * e[6];
    adj[5] = e[3] * e[2] - e[0] * e[5];
    adj[6] = e[3] * e[7] - e[6] * e[4];
    adj[7] = e[6] * e[1] - e[0] * e[7];
    adj[8] = e[0] * e[4] - e[3] * e[1];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    dmag = det < 0 ? -det : det;
    for (int i = 0; i < 9; i++) begin
      num  = (adj[i] < 0 ? -adj[i] : adj[i]) <<< (2 * m3i_pkg::FRAC_BITS);
      quot = $unsigned(num) / $unsigned(dmag);
      rem  = $unsigned(num) % $unsigned(dmag);
      if ($unsigned(rem) * 2 >= $unsigned(dmag)) quot = quot + 1;
      neg = (adj[i] < 0) != (det < 0);
      if (neg) begin
        if (quot > (wide_t'(1) <<< (m3i_pkg::WORD_BITS - 1))) begin
          r.overflowed = 1'b1;
          quot = wide_t'(1) <<< (m3i_pkg::WORD_BITS - 1);
        end
        res[i] = m3i_pkg::WORD_BITS'(-quot);
      end else begin
        if (quot > (wide_t'(1) <<< (m3i_pkg::WORD_BITS - 1)) - 1) begin
          r.overflowed = 1'b1;
          quot = (wide_t'(1) <<< (m3i_pkg::WORD_BITS - 1)) - 1;
        end
        res[i] = m3i_pkg::WORD_BITS'(quot);
      end
    end
    for (int row = 0; row < 3; row++)
      for (int col = 0; col < 3; col++)
        r.m[row * 3 + col] = transpose ? res[col * 3 + row] : res[row * 3 + col];
    return r;
  endfunction

  function automatic logic [m3i_pkg::WORD_BITS-1:0] small_value();
    return m3i_pkg::WORD_BITS'(int'($urandom_range(2 * SMALL_SPAN)) - SMALL_SPAN);
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int      kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) m[i] = small_value();
    case (kind)
      0, 1: begin
        for (int i = 0; i < 9; i++) m[i] = $urandom;
      end
      6: begin
        for (int i = 0; i < 9; i += 4) m[i] = m[i] + m3i_pkg::WORD_BITS'(32'sd1 <<< 20);
      end
      7: begin
        for (int i = 0; i < 3; i++) m[6 + i] = m[3 * $urandom_range(1) + i];
      end
      8: begin
        m[$urandom_range(8)] = $urandom;
      end
      9: begin
        for (int i = 0; i < 9; i++) m[i] = m3i_pkg::WORD_BITS'(int'($urandom_range(32)) - 16);
      end
      default: ;
    endcase
    return m;
  endfunction

  function automatic matrix_t diag_matrix(logic [m3i_pkg::WORD_BITS-1:0] d);
    matrix_t m;
    m = '0;
    m[0] = d;
    m[4] = d;
    m[8] = d;
    return m;
  endfunction

  task automatic queue_directed();
    matrix_t m;
    pending_matrices.push_back(diag_matrix(32'h0001_0000));
    pending_matrices.push_back(diag_matrix(32'h0002_0000));
    pending_matrices.push_back(diag_matrix(32'hFFFF_0000));
    pending_matrices.push_back(diag_matrix(32'h0000_0001));
    pending_matrices.push_back(diag_matrix(32'h7FFF_FFFF));
    pending_matrices.push_back(diag_matrix(32'h8000_0000));
    pending_matrices.push_back('0);
    pending_matrices.push_back({9{32'h7FFF_FFFF}});
    pending_matrices.push_back({9{32'h8000_0000}});
    pending_matrices.push_back({9{32'hFFFF_FFFF}});
    m = diag_matrix(32'h0001_0000);
    m[1] = 32'h0003_0000;
    m[5] = 32'hFFFE_8000;
    m[6] = 32'h0000_4000;
    pending_matrices.push_back(m);
    m = '0;
    m[1] = 32'h0001_0000;
    m[5] = 32'h0002_0000;
    m[6] = 32'h0003_0000;
    pending_matrices.push_back(m);
    m = diag_matrix(32'h7FFF_FFFF);
    m[2] = 32'h8000_0000;
    m[3] = 32'h8000_0000;
    m[7] = 32'h7FFF_FFFF;
    pending_matrices.push_back(m);
    m = diag_matrix(32'h0001_0000);
    m[8] = '0;
    pending_matrices.push_back(m);
    m = diag_matrix(32'h0003_0000);
    pending_matrices.push_back(m);
    m = diag_matrix(32'h0000_0100);
    m[4] = 32'h0100_0000;
    pending_matrices.push_back(m);
  endtask

  task automatic write_register(logic [m3i_pkg::ADDR_W-1:0] addr,
                                logic [m3i_pkg::DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_TRANSPOSE) transpose_shadow = value[0];
  endtask

  task automatic wait_drained();
    while (pending_matrices.size() != 0 || expected_inverses.size() != 0 || in_ch.valid)
      @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(99) >= recv_stall_pct;
      if (!in_ch.valid || took_matrix) begin
        if (pending_matrices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          matrix_t m;
          m = pending_matrices.pop_front();
          in_ch.in_r0c0 <= m[0];
          in_ch.in_r0c1 <= m[1];
          in_ch.in_r0c2 <= m[2];
          in_ch.in_r1c0 <= m[3];
          in_ch.in_r1c1 <= m[4];
          in_ch.in_r1c2 <= m[5];
          in_ch.in_r2c0 <= m[6];
          in_ch.in_r2c1 <= m[7];
          in_ch.in_r2c2 <= m[8];
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    took_matrix = 1'b0;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("matrix3_inverse_test failed");
      $finish;
    end else if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        took_matrix = 1'b1;
        expected_inverses.push_back(invert_matrix({in_ch.in_r2c2, in_ch.in_r2c1,
          in_ch.in_r2c0, in_ch.in_r1c2, in_ch.in_r1c1, in_ch.in_r1c0, in_ch.in_r0c2,
          in_ch.in_r0c1, in_ch.in_r0c0}, transpose_shadow));
      end
      if (out_ch.valid && out_ch.ready) begin
        m3i_pkg::out_item_t want;
        m3i_pkg::out_item_t got;
        string              names[9];
        names = '{"out_r0c0", "out_r0c1", "out_r0c2", "out_r1c0", "out_r1c1",
                  "out_r1c2", "out_r2c0", "out_r2c1", "out_r2c2"};
        got.m = {out_ch.out_r2c2, out_ch.out_r2c1, out_ch.out_r2c0, out_ch.out_r1c2,
                 out_ch.out_r1c1, out_ch.out_r1c0, out_ch.out_r0c2, out_ch.out_r0c1,
                 out_ch.out_r0c0};
        got.singular   = out_ch.singular;
        got.overflowed = out_ch.overflowed;
        if (expected_inverses.size() == 0) begin
          $error("unexpected item on out_o");
          fail_count++;
        end else begin
          want = expected_inverses.pop_front();
          for (int i = 0; i < 9; i++)
            if (got.m[i] !== want.m[i]) begin
              $error("%s expected %h actual %h", names[i], want.m[i], got.m[i]);
              fail_count++;
            end
          if (got.singular !== want.singular) begin
            $error("singular expected %b actual %b", want.singular, got.singular);
            fail_count++;
          end
          if (got.overflowed !== want.overflowed) begin
            $error("overflowed expected %b actual %b", want.overflowed, got.overflowed);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int idle_modes[4][2];
    idle_modes = '{'{0, 0}, '{61, 0}, '{0, 61}, '{27, 27}};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.in_r0c0 = '0;
    in_ch.in_r0c1 = '0;
    in_ch.in_r0c2 = '0;
    in_ch.in_r1c0 = '0;
    in_ch.in_r1c1 = '0;
    in_ch.in_r1c2 = '0;
    in_ch.in_r2c0 = '0;
    in_ch.in_r2c1 = '0;
    in_ch.in_r2c2 = '0;
    out_ch.ready = 1'b0;
    transpose_shadow = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    took_matrix = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    queue_directed();
    wait_drained();
    for (int p = 0; p < 8; p++) begin
      write_register(ADDR_TRANSPOSE,
                     {$urandom} & ~m3i_pkg::DATA_W'(1) | m3i_pkg::DATA_W'(p % 2));
      send_idle_pct  = idle_modes[p % 4][0];
      recv_stall_pct = idle_modes[p % 4][1];
      if (p == 1) queue_directed();
      for (int i = 0; i < 85; i++) pending_matrices.push_back(random_matrix());
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("matrix3_inverse_test passed");
    end else begin
      $display("matrix3_inverse_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/m3i_pkg.sv
rtl/core/m3i_in_if.sv
rtl/core/m3i_out_if.sv
rtl/core/m3i_cfg.sv
rtl/core/m3i_front.sv
rtl/core/m3i_div_lane.sv
rtl/core/matrix3_inverse.sv
test/matrix3_inverse_test.sv
